// File: src/trle_pkg.sv
package trle_pkg;

    // Fixed field widths of the two channels and the configuration register.
    localparam int BYTE_W  = 8;
    localparam int DATA_W  = 64;
    localparam int CNT_W   = 4;
    localparam int LEFT_W  = 10;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 3;

    // Header byte layout.
    localparam int HDR_TYPE_BIT = 7;
    localparam int HDR_LEN_W    = 7;

    // Pixel size after reset.
    localparam logic [CFG_W-1:0] CFG_PB_RESET = 3'd4;

    // Decoder sequencer states.
    typedef enum logic [1:0] {
        ST_HEADER,
        ST_COLLECT,
        ST_LITERAL,
        ST_EMIT
    } t_state;

    // Requests from the sequencer to the packer.
    typedef struct packed {
        logic              start;
        logic              lit;
        logic [LEFT_W-1:0] total;
        logic [BYTE_W-1:0] lit_byte;
    } t_pack_req;

    // Status from the packer back to the sequencer.
    typedef struct packed {
        logic busy;
        logic slot_free;
    } t_pack_stat;

endpackage

// File: src/trle_if.sv
interface trle_in_if
    import trle_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface trle_out_if
    import trle_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] out_data;
    logic [CNT_W-1:0]  byte_count;
    logic              last_of_run;

    modport source (output valid, output out_data, output byte_count, output last_of_run,
                    input ready);
    modport sink   (input valid, input out_data, input byte_count, input last_of_run,
                    output ready);
endinterface

// File: src/trle_packer.sv
module trle_packer
    import trle_pkg::*;
#(
    parameter int MAX_PIXEL_BYTES = 4,
    parameter int OUT_BYTES       = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_pack_req          i_req,
    input  logic [IDX_W-1:0]   i_pb,
    input  logic [BYTE_W-1:0]  i_pixel [MAX_PIXEL_BYTES],
    output t_pack_stat         o_stat,
    trle_out_if.source         o_pix_ch
);

    localparam int PW    = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam int OW    = (OUT_BYTES > 1) ? $clog2(OUT_BYTES) : 1;
    localparam int ASM_W = BYTE_W * OUT_BYTES;

    logic              r_busy;
    logic [LEFT_W-1:0] r_left;
    logic [PW-1:0]     r_phase;
    logic [CNT_W-1:0]  r_cnt;
    logic [ASM_W-1:0]  r_asm;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;
    logic [CNT_W-1:0]  r_out_cnt;
    logic              r_out_last;

    logic              slot_free;
    logic [BYTE_W-1:0] step_byte;
    logic              word_done;
    logic              run_end;
    logic              advance;
    logic [ASM_W-1:0]  asm_next;
    logic [IDX_W-1:0]  ph_inc;
    logic [PW-1:0]     phase_next;

    // The output register can take a new word when empty or when its word transfers.
    assign slot_free = !r_out_valid || o_pix_ch.ready;

    // One pattern byte per cycle, unless a finished word waits, drops into its lane.
    assign step_byte = i_pixel[r_phase];
    assign run_end   = (r_left == LEFT_W'(1));
    assign word_done = (r_cnt == CNT_W'(OUT_BYTES - 1)) || run_end;
    assign advance   = r_busy && (!word_done || slot_free);

    always_comb begin
        asm_next = r_asm;
        for (int j = 0; j < OUT_BYTES; j++) begin
            if (r_cnt[OW-1:0] == OW'(j)) begin
                asm_next[BYTE_W*j +: BYTE_W] = step_byte;
            end
        end
    end

    // Pattern position wraps at the pixel size.
    assign ph_inc     = IDX_W'(r_phase) + IDX_W'(1);
    assign phase_next = (ph_inc >= i_pb) ? '0 : ph_inc[PW-1:0];

    // Run assembly state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_left  <= '0;
            r_phase <= '0;
            r_cnt   <= '0;
            r_asm   <= '0;
        end else if (i_req.start) begin
            r_busy  <= 1'b1;
            r_left  <= i_req.total;
            r_phase <= '0;
            r_cnt   <= '0;
            r_asm   <= '0;
        end else if (advance) begin
            r_left  <= r_left - LEFT_W'(1);
            r_phase <= phase_next;
            if (run_end) begin
                r_busy <= 1'b0;
            end
            if (word_done) begin
                r_cnt <= '0;
                r_asm <= '0;
            end else begin
                r_cnt <= r_cnt + CNT_W'(1);
                r_asm <= asm_next;
            end
        end
    end

    // Output register, loaded by a finished word or by a literal byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && word_done) begin
            r_out_valid <= 1'b1;
        end else if (i_req.lit) begin
            r_out_valid <= 1'b1;
        end else if (o_pix_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && word_done) begin
            r_out_data <= DATA_W'(asm_next);
            r_out_cnt  <= r_cnt + CNT_W'(1);
            r_out_last <= run_end;
        end else if (i_req.lit) begin
            r_out_data <= DATA_W'(i_req.lit_byte);
            r_out_cnt  <= CNT_W'(1);
            r_out_last <= 1'b1;
        end
    end

    assign o_pix_ch.valid       = r_out_valid;
    assign o_pix_ch.out_data    = r_out_data;
    assign o_pix_ch.byte_count  = r_out_cnt;
    assign o_pix_ch.last_of_run = r_out_last;

    assign o_stat.busy      = r_busy;
    assign o_stat.slot_free = slot_free;

endmodule

// File: src/tga_rle_pixel_decoder.sv
// Run-length image stream decoder. Compressed bytes arrive one per transfer on
// i_byte_ch; decoded bytes leave on o_pix_ch packed up to OUT_BYTES per transfer,
// first byte in the low lane, with last_of_run set on the final word caused by an
// input byte. Header bytes and repeat pixel bytes are taken one per cycle, and a
// literal byte is taken in the cycle the output register is free and passes through
// as a one-byte word. The last byte of a repeat pixel hands the run to the packer,
// which fills one byte lane per cycle unless a finished word waits for the output
// register; input stays stalled for the whole run and is taken again once the final
// word has entered the output register and the sequencer has returned to its header
// state. The pixel size (1 to MAX_PIXEL_BYTES, 0 acts as 1, larger values as the
// maximum) is written through i_cfg_we and i_cfg_wdata and resets to 4; the user must
// write it only while the decoder is idle, as the block itself does not enforce this.
module tga_rle_pixel_decoder
    import trle_pkg::*;
#(
    parameter int MAX_PIXEL_BYTES = 4,
    parameter int OUT_BYTES       = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    trle_in_if.sink          i_byte_ch,
    trle_out_if.source       o_pix_ch
);

    localparam int PW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

    logic [CFG_W-1:0]  r_cfg_pb;
    t_state            r_state;
    t_state            n_state;
    logic [LEFT_W-1:0] r_left;
    logic [LEFT_W-1:0] n_left;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  n_idx;
    logic [BYTE_W-1:0] r_pixel [MAX_PIXEL_BYTES];

    logic [IDX_W-1:0]  pb;
    logic              in_ready;
    logic              accept;
    logic              pix_we;
    logic [IDX_W-1:0]  idx_inc;
    logic [LEFT_W-1:0] hdr_len;
    t_pack_req         pack_req;
    t_pack_stat        pack_stat;

    // Pixel size register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_pb <= CFG_PB_RESET;
        end else if (i_cfg_we) begin
            r_cfg_pb <= i_cfg_wdata;
        end
    end

    // Effective pixel size, clamped to the supported range.
    always_comb begin
        if (r_cfg_pb == '0) begin
            pb = IDX_W'(1);
        end else if (r_cfg_pb > CFG_W'(MAX_PIXEL_BYTES)) begin
            pb = IDX_W'(MAX_PIXEL_BYTES);
        end else begin
            pb = r_cfg_pb;
        end
    end

    // Literal bytes need the output register; the packer run blocks input entirely.
    always_comb begin
        if (r_state inside {ST_HEADER, ST_COLLECT}) begin
            in_ready = 1'b1;
        end else if (r_state == ST_LITERAL) begin
            in_ready = pack_stat.slot_free;
        end else begin
            in_ready = 1'b0;
        end
    end

    assign i_byte_ch.ready = in_ready;
    assign accept          = i_byte_ch.valid && in_ready;

    assign hdr_len = (LEFT_W'(i_byte_ch.in_byte[HDR_LEN_W-1:0]) + LEFT_W'(1)) * LEFT_W'(pb);
    assign idx_inc = r_idx + IDX_W'(1);

    // Sequencer: next state and packer requests.
    always_comb begin
        n_state           = r_state;
        n_left            = r_left;
        n_idx             = r_idx;
        pix_we            = 1'b0;
        pack_req.start    = 1'b0;
        pack_req.lit      = 1'b0;
        pack_req.total    = r_left;
        pack_req.lit_byte = i_byte_ch.in_byte;
        case (r_state)
            ST_COLLECT: begin
                if (accept) begin
                    pix_we = 1'b1;
                    n_idx  = idx_inc;
                    if (idx_inc >= pb) begin
                        n_idx  = '0;
                        n_left = '0;
                        if (r_left != '0) begin
                            pack_req.start = 1'b1;
                            n_state        = ST_EMIT;
                        end else begin
                            n_state = ST_HEADER;
                        end
                    end
                end
            end
            ST_LITERAL: begin
                if (accept) begin
                    if (r_left != '0) begin
                        pack_req.lit = 1'b1;
                        n_left       = r_left - LEFT_W'(1);
                        if (r_left == LEFT_W'(1)) begin
                            n_state = ST_HEADER;
                        end
                    end else begin
                        n_state = ST_HEADER;
                    end
                end
            end
            ST_EMIT: begin
                if (!pack_stat.busy) begin
                    n_state = ST_HEADER;
                end
            end
            default: begin
                if (accept) begin
                    n_left  = hdr_len;
                    n_idx   = '0;
                    n_state = i_byte_ch.in_byte[HDR_TYPE_BIT] ? ST_COLLECT : ST_LITERAL;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HEADER;
            r_left  <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
            r_idx   <= n_idx;
        end
    end

    // Repeat pixel store; indexes past the array are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < MAX_PIXEL_BYTES; j++) begin
                r_pixel[j] <= '0;
            end
        end else if (pix_we && (r_idx < IDX_W'(MAX_PIXEL_BYTES))) begin
            r_pixel[r_idx[PW-1:0]] <= i_byte_ch.in_byte;
        end
    end

    trle_packer #(
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES),
        .OUT_BYTES       (OUT_BYTES)
    ) u_packer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (pack_req),
        .i_pb     (pb),
        .i_pixel  (r_pixel),
        .o_stat   (pack_stat),
        .o_pix_ch (o_pix_ch)
    );

endmodule

// File: src/trle_checker.sv
module trle_checker
    import trle_pkg::*;
#(
    parameter int OUT_BYTES = 8
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [DATA_W-1:0] i_out_data,
    input logic [CNT_W-1:0]  i_out_count,
    input logic              i_out_last
);

    // A word always carries at least one byte and never more than the lane count.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_count != '0) && (i_out_count <= CNT_W'(OUT_BYTES)))
        else $error("result byte count out of range");

    // Only the final word of a run may be short.
    a_full_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_last) |-> (i_out_count == CNT_W'(OUT_BYTES)))
        else $error("short word before the end of a run");

    // While a run is still being delivered, no new input byte is taken.
    a_stall_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_last) |-> !i_in_ready)
        else $error("input ready in the middle of a repeat run");

    // A stalled word holds until its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_data) && $stable(i_out_count)
             && $stable(i_out_last)))
        else $error("stalled result changed");

endmodule

bind tga_rle_pixel_decoder trle_checker #(
    .OUT_BYTES (OUT_BYTES)
) u_trle_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_byte_ch.ready),
    .i_out_valid (o_pix_ch.valid),
    .i_out_ready (o_pix_ch.ready),
    .i_out_data  (o_pix_ch.out_data),
    .i_out_count (o_pix_ch.byte_count),
    .i_out_last  (o_pix_ch.last_of_run)
);

// File: tb/tga_rle_pixel_decoder_tb.sv
`timescale 1ns / 100ps

module tga_rle_pixel_decoder_tb;
    import trle_pkg::*;

    localparam int MAX_PB         = 4;
    localparam int OUT_LANES      = 8;
    localparam int SETTLE_CYCLES  = 24;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT    = 4000;
    localparam int PHASES         = 8;
    localparam int PHASE_BYTES    = 30;

    // Tracks the decoder state and the packed words each stream byte is owed.
    class rle_decode_tracker;
        typedef struct packed {
            logic [DATA_W-1:0] data;
            logic [CNT_W-1:0]  count;
            logic              last;
        } t_word;

        t_word             owed_words[$];
        logic [CFG_W-1:0]  pixel_bytes;
        t_state            mode;
        logic [LEFT_W-1:0] bytes_left;
        logic [IDX_W-1:0]  pix_idx;
        logic [BYTE_W-1:0] rep_pixel [MAX_PB];
        int                errors;
        int                bytes_taken;
        int                words_matched;

        function new();
            pixel_bytes   = CFG_PB_RESET;
            mode          = ST_HEADER;
            bytes_left    = '0;
            pix_idx       = '0;
            errors        = 0;
            bytes_taken   = 0;
            words_matched = 0;
            foreach (rep_pixel[i]) rep_pixel[i] = '0;
        endfunction

        // Zero acts as one byte and anything above the maximum as the maximum.
        function int unsigned pixel_size();
            int unsigned p;
            p = pixel_bytes;
            if (p == 0) p = 1;
            if (p > MAX_PB) p = MAX_PB;
            return p;
        endfunction

        // Advances the decoder by one accepted stream byte.
        function void take_stream_byte(input logic [BYTE_W-1:0] b);
            int unsigned       pb;
            int unsigned       total;
            int unsigned       k;
            int unsigned       lanes;
            int unsigned       idx;
            logic [DATA_W-1:0] data;
            pb = pixel_size();
            bytes_taken++;
            case (mode)
                ST_COLLECT: begin
                    idx = pix_idx;
                    if (idx < MAX_PB) rep_pixel[idx] = b;
                    pix_idx = IDX_W'(idx + 1);
                    // The last pixel byte releases the whole run at once.
                    if (pix_idx >= pb) begin
                        total = bytes_left;
                        k     = 0;
                        while (k < total) begin
                            data  = '0;
                            lanes = 0;
                            while (lanes < OUT_LANES && k < total) begin
                                data  = data | (DATA_W'(rep_pixel[k % pb]) << (8 * lanes));
                                lanes++;
                                k++;
                            end
                            owed_words.push_back('{data, CNT_W'(lanes), k >= total});
                        end
                        bytes_left = '0;
                        pix_idx    = '0;
                        mode       = ST_HEADER;
                    end
                end
                ST_LITERAL: begin
                    if (bytes_left != 0) begin
                        owed_words.push_back('{DATA_W'(b), CNT_W'(1), 1'b1});
                        bytes_left = bytes_left - 1'b1;
                    end
                    if (bytes_left == 0) mode = ST_HEADER;
                end
                default: begin
                    bytes_left = LEFT_W'((b[HDR_LEN_W-1:0] + 1) * pb);
                    pix_idx    = '0;
                    mode       = b[HDR_TYPE_BIT] ? ST_COLLECT : ST_LITERAL;
                end
            endcase
        endfunction

        // Compares one output transfer with the oldest owed word.
        function void match_word(input logic [DATA_W-1:0] data, input logic [CNT_W-1:0] count,
                                 input logic last);
            t_word want;
            words_matched++;
            if (owed_words.size() == 0) begin
                $error("unexpected word: out_data %h byte_count %0d last_of_run %0b",
                       data, count, last);
                errors++;
                return;
            end
            want = owed_words.pop_front();
            if (data !== want.data) begin
                $error("out_data: expected %h, actual %h", want.data, data);
                errors++;
            end
            if (count !== want.count) begin
                $error("byte_count: expected %0d, actual %0d", want.count, count);
                errors++;
            end
            if (last !== want.last) begin
                $error("last_of_run: expected %0b, actual %0b", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    trle_in_if  byte_ch ();
    trle_out_if pix_ch ();

    rle_decode_tracker decoder = new();

    int tx_gap_pct   = 0;
    int rx_stall_pct = 0;
    int rx_hold_reqs = 0;
    int rx_hold_seen = 0;
    int rx_hold_left = 0;
    int quiet_cycles = 0;
    int cfg_writes   = 0;

    tga_rle_pixel_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_byte_ch   (byte_ch),
        .o_pix_ch    (pix_ch)
    );

    // Free-running clock.
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Receiver: random stalls, plus a long hold-off counted here on request.
    always @(posedge i_clk) begin
        if (rx_hold_seen != rx_hold_reqs) begin
            rx_hold_left = RX_HOLD_CYCLES;
            rx_hold_seen = rx_hold_reqs;
        end
        if (rx_hold_left > 0) begin
            pix_ch.ready <= 1'b0;
            rx_hold_left--;
        end else begin
            pix_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Every output transfer is checked against the oldest owed word.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1) begin
            decoder.match_word(pix_ch.out_data, pix_ch.byte_count, pix_ch.last_of_run);
        end
    end

    // Watchdog on cycles without any transfer on either channel.
    always @(posedge i_clk) begin
        if ((byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1) ||
            (pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tga_rle_pixel_decoder regression: fail");
                $finish;
            end
        end
    end

    // Offers one byte, with a random gap first, and returns after its transfer.
    task automatic push_byte(input logic [BYTE_W-1:0] b);
        if ($urandom_range(99) < tx_gap_pct) begin
            byte_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_gap_pct);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.in_byte <= b;
        do @(posedge i_clk); while (byte_ch.ready !== 1'b1);
        decoder.take_stream_byte(b);
    endtask

    // Stops offering and waits until every owed word has arrived and the block is quiet.
    task automatic settle();
        byte_ch.valid <= 1'b0;
        while (decoder.owed_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_pixel_size(input logic [CFG_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        decoder.pixel_bytes = v;
        cfg_writes++;
    endtask

    task automatic send_repeat(input logic [HDR_LEN_W-1:0] len);
        push_byte({1'b1, len});
        repeat (decoder.pixel_size()) push_byte(BYTE_W'($urandom_range(255)));
    endtask

    task automatic send_literal(input logic [HDR_LEN_W-1:0] len);
        push_byte({1'b0, len});
        repeat ((len + 1) * decoder.pixel_size()) push_byte(BYTE_W'($urandom_range(255)));
    endtask

    // Mostly well-formed packets with random content, some raw noise bytes.
    task automatic send_random_packet();
        int unsigned pick;
        int unsigned span;
        pick = $urandom_range(99);
        span = $urandom_range(99);
        if (pick < 85) begin
            while (decoder.mode != ST_HEADER) push_byte(BYTE_W'($urandom_range(255)));
        end
        if (pick < 45) begin
            if (span < 10) send_repeat(7'h7F);
            else if (span < 70) send_repeat(HDR_LEN_W'($urandom_range(7)));
            else send_repeat(HDR_LEN_W'($urandom_range(127)));
        end else if (pick < 85) begin
            if (span < 60) send_literal(HDR_LEN_W'($urandom_range(3)));
            else send_literal(HDR_LEN_W'($urandom_range(15)));
        end else begin
            repeat ($urandom_range(1, 4)) push_byte(BYTE_W'($urandom_range(255)));
        end
    endtask

    initial begin
        logic [CFG_W-1:0] pb_setting;
        int               target;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        byte_ch.valid   = 1'b0;
        byte_ch.in_byte = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Longest repeat run at the reset pixel size, with extreme pixel bytes.
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h80);
        push_byte(8'h7F);
        // Short literal packet at the reset pixel size.
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'h7F);
        push_byte(8'h80);
        settle();

        // Smallest pixel size: a single-byte run and a single-byte literal.
        set_pixel_size(3'd1);
        push_byte(8'h80);
        push_byte(8'hA5);
        push_byte(8'h00);
        push_byte(8'h3C);
        settle();

        // A pixel size of zero behaves as one byte.
        set_pixel_size(3'd0);
        push_byte(8'h83);
        push_byte(8'h5A);
        settle();

        // An oversized pixel size behaves as the maximum.
        set_pixel_size(3'd7);
        push_byte(8'h81);
        push_byte(8'h01);
        push_byte(8'h02);
        push_byte(8'h03);
        push_byte(8'h04);

        // Pixel size shrinks while a repeat pixel is half collected.
        push_byte(8'h81);
        push_byte(8'h11);
        push_byte(8'h22);
        settle();
        set_pixel_size(3'd2);
        push_byte(8'h33);
        settle();

        // Random phases, each with its own pixel size and idle mix.
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: pb_setting = 3'd3;
                1: pb_setting = 3'd1;
                2: pb_setting = 3'd4;
                3: pb_setting = 3'd2;
                4: pb_setting = 3'd0;
                5: pb_setting = 3'd7;
                6: pb_setting = 3'd5;
                default: pb_setting = CFG_W'($urandom_range(7));
            endcase
            set_pixel_size(pb_setting);
            case (ph % 4)
                0: begin
                    tx_gap_pct   = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_gap_pct   = 66;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_gap_pct   = 0;
                    rx_stall_pct = 66;
                end
                default: begin
                    tx_gap_pct   = 12;
                    rx_stall_pct = 12;
                end
            endcase
            // The receiver holds off while a long run backs up into the input.
            if (ph == 0) begin
                rx_hold_reqs++;
                send_repeat(HDR_LEN_W'($urandom_range(16, 127)));
            end
            target = decoder.bytes_taken + PHASE_BYTES;
            while (decoder.bytes_taken < target) send_random_packet();
            while (decoder.mode != ST_HEADER) push_byte(BYTE_W'($urandom_range(255)));
            settle();
        end

        if (decoder.owed_words.size() != 0) begin
            $error("%0d owed words never arrived", decoder.owed_words.size());
            decoder.errors++;
        end
        $display("Covered %0d stream bytes and %0d packed words over %0d pixel-size writes,",
                 decoder.bytes_taken, decoder.words_matched, cfg_writes);
        $display("with a long output hold-off and idle/stall mixes on both channels.");
        if (decoder.errors == 0) begin
            $display("tga_rle_pixel_decoder regression: pass");
        end else begin
            $display("tga_rle_pixel_decoder regression: fail");
        end
        $finish;
    end

endmodule

// File: sim.f
src/trle_pkg.sv
src/trle_if.sv
src/trle_packer.sv
src/tga_rle_pixel_decoder.sv
src/trle_checker.sv
tb/tga_rle_pixel_decoder_tb.sv
